// ===== src/pfa_pkg.sv =====
// Shared types and codes for the page frame allocator.
// No dependencies; imported by every pfa module and the core top level.
`default_nettype none

package pfa_pkg;

  localparam int PAGE_W   = 15;
  localparam int LIMIT_W  = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int NEWCNT_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32768;

  // operations
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INC   = 2'd2;
  localparam logic [OP_W-1:0] OP_DEC   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT   = 1'b1;

  typedef struct packed {
    logic rd;
    logic wr;
  } pfa_cnt_cmd_t;

  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
  } pfa_stk_cmd_t;

endpackage

`default_nettype wire

// ===== src/refcounted_page_frame_allocator_core.sv =====
// Page frame allocator with reference counts: top level and control.
// Uses pfa_pkg, pfa_count_ram and pfa_free_stack.
//
// Input channel (in_valid/in_stall) takes one item per operation: allocate,
// free, increase or decrease reference on in_page_number. Each item gives
// exactly one result on the output channel (out_valid/out_stall): status,
// granted page, a pushed-to-free-stack flag and the page's new count.
// The config port (cfg_valid/cfg_ready, always ready) writes the lowest
// usable page (index 0) and the exclusive page limit (index 1).
//
// Timing: the item is accepted and the count and stack RAMs are read as
// the FSM enters S_EXEC; in S_EXEC the result is written back and loaded
// into the output register. No new item is taken before that write-back,
// set by the read-then-write of the count table and stack RAMs.
// The output register holds a result while out_stall is high; a new item
// is still taken if the result leaves at the same edge.
// Reset empties the stack and then sweeps the count table to zero, one
// entry per cycle; in_stall stays high for the whole sweep.
`default_nettype none

module refcounted_page_frame_allocator_core #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [pfa_pkg::OP_W-1:0]          in_operation,
  input  wire [pfa_pkg::PAGE_W-1:0]        in_page_number,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [pfa_pkg::STATUS_W-1:0]     out_status,
  output logic [pfa_pkg::PAGE_W-1:0]       out_granted_page,
  output logic                             out_page_returned,
  output logic [pfa_pkg::NEWCNT_W-1:0]     out_new_count,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [pfa_pkg::LIMIT_W-1:0]       cfg_data
);
  import pfa_pkg::*;

  localparam int AW = $clog2(NUM_PAGES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_r;
  logic                  state_nxt;
  logic [OP_W-1:0]       op_r;
  logic [PAGE_W-1:0]     page_r;
  logic [PAGE_W-1:0]     first_r;
  logic [LIMIT_W-1:0]    limit_r;

  logic                  in_acc;
  logic                  exec;
  logic                  in_pg_ok;
  logic                  pg_ok;

  pfa_cnt_cmd_t          cnt_cmd;
  logic [AW-1:0]         cnt_wr_addr;
  logic [COUNT_BITS-1:0] cnt_wr_data;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  cnt_busy;

  pfa_stk_cmd_t          stk_cmd;
  logic [PAGE_W-1:0]     stk_q;
  logic                  stk_empty;
  logic                  stk_full;

  logic [STATUS_W-1:0]   status_c;
  logic [PAGE_W-1:0]     granted_c;
  logic                  returned_c;
  logic [COUNT_BITS-1:0] count_c;
  logic                  push_req;
  logic [COUNT_BITS-1:0] cnt_dec;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [PAGE_W-1:0]     out_granted_r;
  logic                  out_returned_r;
  logic [NEWCNT_W-1:0]   out_count_r;

  // ---------------- config ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST_USABLE: first_r <= cfg_data[PAGE_W-1:0];
        CFG_PAGE_LIMIT:   limit_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign in_stall = cnt_busy || (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign exec     = (state_r == S_EXEC);
  assign in_pg_ok = (32'(in_page_number) < NUM_PAGES);
  assign pg_ok    = (32'(page_r) < NUM_PAGES);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_operation;
      page_r <= in_page_number;
    end
  end

  // ---------------- execute: modify and write back ----------------
  assign cnt_dec = cnt_q - 1'b1;

  always_comb begin
    status_c    = ST_OK;
    granted_c   = '0;
    returned_c  = 1'b0;
    count_c     = '0;
    push_req    = 1'b0;
    cnt_cmd.rd  = in_acc && (in_operation != OP_ALLOC) && in_pg_ok;
    cnt_cmd.wr  = 1'b0;
    cnt_wr_addr = AW'(page_r);
    cnt_wr_data = cnt_q;
    stk_cmd.rd  = in_acc && (in_operation == OP_ALLOC) && !stk_empty;
    stk_cmd.pop = 1'b0;

    if (op_r == OP_ALLOC) begin
      if (stk_empty) begin
        status_c = ST_EMPTY;
      end else begin
        stk_cmd.pop = exec;
        granted_c   = stk_q;
        cnt_cmd.wr  = exec;
        cnt_wr_addr = AW'(stk_q);
        cnt_wr_data = COUNT_BITS'(1);
        count_c     = COUNT_BITS'(1);
      end
    end else if (!pg_ok) begin
      status_c = ST_RANGE;
    end else begin
      case (op_r)
        OP_FREE: begin
          count_c = cnt_q;
          if (cnt_q > COUNT_BITS'(1)) begin
            cnt_cmd.wr  = exec;
            cnt_wr_data = cnt_dec;
            count_c     = cnt_dec;
          end else begin
            push_req = 1'b1;
          end
        end
        OP_INC: begin
          count_c = cnt_q;
          if (cnt_q == '0) begin
            status_c = ST_ZERO;
          end else if (&cnt_q) begin
            status_c = ST_SAT;
          end else begin
            cnt_cmd.wr  = exec;
            cnt_wr_data = cnt_q + 1'b1;
            count_c     = cnt_q + 1'b1;
          end
        end
        default: begin
          count_c = cnt_q;
          if (cnt_q == '0) begin
            status_c = ST_ZERO;
          end else begin
            cnt_cmd.wr  = exec;
            cnt_wr_data = cnt_dec;
            count_c     = cnt_dec;
            push_req    = (cnt_dec == '0);
          end
        end
      endcase
    end

    // range-checked push; dropped silently when the stack is full
    if (push_req) begin
      if (page_r < first_r || {1'b0, page_r} >= limit_r) begin
        status_c = ST_RANGE;
      end else if (!stk_full) begin
        returned_c = 1'b1;
      end
    end

    stk_cmd.push = exec && returned_c;
  end

  pfa_count_ram #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_count_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cnt_cmd),
    .rd_addr (AW'(in_page_number)),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_data (cnt_q),
    .busy    (cnt_busy)
  );

  pfa_free_stack #(
    .NUM_PAGES (NUM_PAGES)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stk_cmd),
    .push_page (page_r),
    .rd_page   (stk_q),
    .empty     (stk_empty),
    .full      (stk_full)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_status_r   <= status_c;
      out_granted_r  <= granted_c;
      out_returned_r <= returned_c;
      out_count_r    <= NEWCNT_W'(count_c);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_page  = out_granted_r;
  assign out_page_returned = out_returned_r;
  assign out_new_count     = out_count_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC)
    else $error("accepted item did not enter execute");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> !out_valid_r ##1 out_valid_r)
    else $error("result register not free or not loaded");

  a_stall_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_busy |-> in_stall && !exec)
    else $error("item taken during clearing pass");

endmodule

`default_nettype wire

// ===== src/pfa_count_ram.sv =====
// Reference count table: one synchronous RAM with a registered read.
// Runs a zero-fill sweep after reset. Uses pfa_pkg.
`default_nettype none

module pfa_count_ram #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  pfa_pkg::pfa_cnt_cmd_t          cmd,
  input  wire [$clog2(NUM_PAGES)-1:0]    rd_addr,
  input  wire [$clog2(NUM_PAGES)-1:0]    wr_addr,
  input  wire [COUNT_BITS-1:0]           wr_data,
  output logic [COUNT_BITS-1:0]          rd_data,
  output logic                           busy
);
  import pfa_pkg::*;

  localparam int AW = $clog2(NUM_PAGES);

  logic [COUNT_BITS-1:0] mem_r [NUM_PAGES];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [AW-1:0]         clr_idx_r;
  logic                  busy_r;

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem_r[clr_idx_r] <= '0;
    end else if (cmd.wr) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // clearing pass: one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      if (clr_idx_r == AW'(NUM_PAGES - 1)) begin
        busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

  a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !cmd.wr && !cmd.rd)
    else $error("count table accessed during clearing pass");

  a_clear_ends_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> clr_idx_r == AW'(NUM_PAGES))
    else $error("clearing pass ended early");

  a_clear_starts_at_zero: assert property (@(posedge clk)
    !rst_n |=> busy_r && clr_idx_r == '0)
    else $error("clearing pass not restarted by reset");

endmodule

`default_nettype wire

// ===== src/pfa_free_stack.sv =====
// LIFO free page stack: synchronous RAM plus depth register.
// Pop data is registered by the read, ahead of the pop. Uses pfa_pkg.
`default_nettype none

module pfa_free_stack #(
  parameter int NUM_PAGES = 32768
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  pfa_pkg::pfa_stk_cmd_t          cmd,
  input  wire [pfa_pkg::PAGE_W-1:0]      push_page,
  output logic [pfa_pkg::PAGE_W-1:0]     rd_page,
  output logic                           empty,
  output logic                           full
);
  import pfa_pkg::*;

  localparam int AW = $clog2(NUM_PAGES);
  localparam int DW = $clog2(NUM_PAGES + 1);

  logic [PAGE_W-1:0] mem_r [NUM_PAGES];
  logic [PAGE_W-1:0] rd_page_r;
  logic [DW-1:0]     depth_r;
  logic [DW-1:0]     depth_nxt;
  logic [DW-1:0]     top_idx;

  assign top_idx = depth_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_r[AW'(depth_r)] <= push_page;
    end
    if (cmd.rd) begin
      rd_page_r <= mem_r[AW'(top_idx)];
    end
  end

  always_comb begin
    depth_nxt = depth_r;
    if (cmd.push) begin
      depth_nxt = depth_r + 1'b1;
    end else if (cmd.pop) begin
      depth_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  assign rd_page = rd_page_r;
  assign empty   = (depth_r == '0);
  assign full    = (depth_r == DW'(NUM_PAGES));

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !full && !cmd.pop)
    else $error("push into full stack");

  a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> $past(cmd.rd) && !empty)
    else $error("pop without a prior top read");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= NUM_PAGES)
    else $error("stack depth out of bounds");

endmodule

`default_nettype wire
